// File: sv/dmss_pkg.sv
`timescale 1ns / 1ps

package dmss_pkg;

    localparam int LetterWidth  = 5;
    localparam int AlphabetSize = 1 << LetterWidth;
    localparam int TableDepth   = AlphabetSize * AlphabetSize;
    localparam int AddrWidth    = 2 * LetterWidth;
    localparam int EntryWidth   = 16;

    localparam int SumWidth     = 31;
    localparam int PosWidth     = 17;
    localparam int StartWidth   = 16;

    localparam logic [PosWidth-1:0] MaxDiagLen = PosWidth'(65536);
    localparam logic [SumWidth-1:0] SumTop     = {SumWidth{1'b1}};

    localparam logic OpLoad = 1'b0;
    localparam logic OpPair = 1'b1;

    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic signed [EntryWidth-1:0] score;
    } t_pair;

    typedef struct packed {
        logic [SumWidth-1:0]   best_score;
        logic [StartWidth-1:0] segment_start;
        logic [PosWidth-1:0]   segment_length;
    } t_result;

    // Count up, stop at the diagonal length limit.
    function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
        return (v < MaxDiagLen) ? v + PosWidth'(1) : MaxDiagLen;
    endfunction

endpackage

// File: sv/dmss_scan.sv
`timescale 1ns / 1ps

module dmss_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dmss_pkg::t_pair  i_pair,
    input  logic             i_advance,
    output dmss_pkg::t_result o_result
);

    logic [dmss_pkg::SumWidth-1:0]   r_run;
    logic [dmss_pkg::SumWidth-1:0]   r_best;
    logic [dmss_pkg::PosWidth-1:0]   r_suffix;
    logic [dmss_pkg::PosWidth-1:0]   r_cur;
    logic [dmss_pkg::StartWidth-1:0] r_bstart;
    logic [dmss_pkg::PosWidth-1:0]   r_blen;
    logic [dmss_pkg::PosWidth-1:0]   r_pos;

    logic [dmss_pkg::SumWidth-1:0]   n_run;
    logic [dmss_pkg::SumWidth-1:0]   n_best;
    logic [dmss_pkg::PosWidth-1:0]   n_suffix;
    logic [dmss_pkg::PosWidth-1:0]   n_cur;
    logic [dmss_pkg::StartWidth-1:0] n_bstart;
    logic [dmss_pkg::PosWidth-1:0]   n_blen;
    logic [dmss_pkg::PosWidth-1:0]   n_pos;

    logic signed [dmss_pkg::SumWidth+1:0] w_sum;
    logic [dmss_pkg::SumWidth-1:0]        w_sat;
    logic                                 w_neg;
    logic                                 w_pos;
    logic                                 w_gt_best;

    assign w_sum = $signed({2'b00, r_run})
                 + $signed({{(dmss_pkg::SumWidth + 2 - dmss_pkg::EntryWidth)
                              {i_pair.score[dmss_pkg::EntryWidth-1]}}, i_pair.score});

    assign w_neg     = w_sum[dmss_pkg::SumWidth+1];
    // Clamp at the top of the 31-bit range.
    assign w_sat     = (!w_neg && w_sum[dmss_pkg::SumWidth]) ? dmss_pkg::SumTop
                                                             : w_sum[dmss_pkg::SumWidth-1:0];
    assign w_pos     = !w_neg && (w_sum[dmss_pkg::SumWidth:0] != '0);
    assign w_gt_best = !w_neg && (w_sat > r_best);

    always_comb begin
        n_run    = r_run;
        n_best   = r_best;
        n_suffix = r_suffix;
        n_cur    = r_cur;
        n_bstart = r_bstart;
        n_blen   = r_blen;
        n_pos    = dmss_pkg::sat_inc(r_pos);
        priority if (w_gt_best) begin
            n_run    = w_sat;
            n_best   = w_sat;
            n_bstart = r_suffix[dmss_pkg::StartWidth-1:0];
            n_cur    = dmss_pkg::sat_inc(r_cur);
            n_blen   = dmss_pkg::sat_inc(r_cur);
        end else if (w_pos) begin
            n_run    = w_sat;
            n_cur    = dmss_pkg::sat_inc(r_cur);
        end else begin
            // Restart the segment after this pair.
            n_run    = '0;
            n_suffix = dmss_pkg::sat_inc(r_pos);
            n_cur    = '0;
        end
    end

    assign o_result.best_score     = n_best;
    assign o_result.segment_start  = n_bstart;
    assign o_result.segment_length = n_blen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_best   <= '0;
            r_suffix <= '0;
            r_cur    <= '0;
            r_bstart <= '0;
            r_blen   <= '0;
            r_pos    <= '0;
        end else if (i_pair.valid && i_advance) begin
            if (i_pair.last) begin
                r_run    <= '0;
                r_best   <= '0;
                r_suffix <= '0;
                r_cur    <= '0;
                r_bstart <= '0;
                r_blen   <= '0;
                r_pos    <= '0;
            end else begin
                r_run    <= n_run;
                r_best   <= n_best;
                r_suffix <= n_suffix;
                r_cur    <= n_cur;
                r_bstart <= n_bstart;
                r_blen   <= n_blen;
                r_pos    <= n_pos;
            end
        end
    end

endmodule

// File: sv/diagonal_max_segment_score.sv
`timescale 1ns / 1ps

// Maximum-scoring segment along one diagonal.
// Input channel (i_in_valid / o_in_ready): each transaction is either a table
// load (i_opcode = load) that writes one signed entry of the 32 x 32
// substitution table at row i_query_letter, column i_target_letter, or a
// letter pair (i_opcode = pair) that is scored through the table and fed
// into a running maximum-segment scan. A pair with i_last_pair set closes
// the diagonal.
// Output channel (o_out_valid / i_out_ready): one transaction per closing
// pair carrying the best score, its start offset and its length.
// Throughput: one transaction per cycle, loads and pairs mixed freely, unless a
// closing pair waits for a busy output register; the table is a single-port RAM
// and each transaction uses it once. A closing pair's RAM read registers at the
// accepting edge and the scan updates into the output register when stage 1
// advances. A load is visible to a pair accepted in the very next cycle.
// Reset clears the scan state and the output valid and holds the input not
// ready; the table contents are kept undefined until loaded.
// When the receiver stalls, the finished result holds in the output register
// and input keeps flowing until another closing pair needs that register.

module diagonal_max_segment_score (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [dmss_pkg::LetterWidth-1:0]   i_query_letter,
    input  logic [dmss_pkg::LetterWidth-1:0]   i_target_letter,
    input  logic signed [dmss_pkg::EntryWidth-1:0] i_entry_value,
    input  logic                               i_last_pair,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dmss_pkg::SumWidth-1:0]      o_best_score,
    output logic [dmss_pkg::StartWidth-1:0]    o_segment_start,
    output logic [dmss_pkg::PosWidth-1:0]      o_segment_length
);

    logic signed [dmss_pkg::EntryWidth-1:0] r_table [dmss_pkg::TableDepth];
    logic signed [dmss_pkg::EntryWidth-1:0] r_rd_data;
    logic                                   r_s1_valid;
    logic                                   r_s1_last;
    logic                                   r_out_valid;
    dmss_pkg::t_result                      r_out;

    logic [dmss_pkg::AddrWidth-1:0] w_addr;
    logic                           w_accept;
    logic                           w_stall;
    logic                           w_advance;
    dmss_pkg::t_pair                w_pair;
    dmss_pkg::t_result              w_result;

    assign w_addr    = {i_query_letter, i_target_letter};
    // Hold stage 1 only when its closing pair finds the output register busy.
    assign w_stall   = r_s1_valid && r_s1_last && r_out_valid && !i_out_ready;
    assign w_advance = !w_stall;
    assign w_accept  = i_in_valid && o_in_ready;

    assign o_in_ready = w_advance && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_opcode == dmss_pkg::OpLoad) begin
                r_table[w_addr] <= i_entry_value;
            end else begin
                r_rd_data <= r_table[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_accept && (i_opcode == dmss_pkg::OpPair);
            r_s1_last  <= i_last_pair;
        end
    end

    assign w_pair.valid = r_s1_valid;
    assign w_pair.last  = r_s1_last;
    assign w_pair.score = r_rd_data;

    dmss_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pair    (w_pair),
        .i_advance (w_advance),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_s1_valid && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid && r_s1_last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_best_score     = r_out.best_score;
    assign o_segment_start  = r_out.segment_start;
    assign o_segment_length = r_out.segment_length;

endmodule

// File: verif/tb_diagonal_max_segment_score.sv
`timescale 1ns / 1ps

// Shadow of the diagonal scan: substitution table plus the running segment state.
class segment_scoreboard;
    logic signed [dmss_pkg::EntryWidth-1:0] subst [dmss_pkg::TableDepth];
    longint            run_sum;
    longint            best_sum;
    int                suffix_start;
    int                cur_len;
    int                best_start;
    int                best_len;
    int                pos;
    dmss_pkg::t_result pending_segments[$];
    int                mismatches;

    function new();
        mismatches = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        run_sum      = 0;
        best_sum     = 0;
        suffix_start = 0;
        cur_len      = 0;
        best_start   = 0;
        best_len     = 0;
        pos          = 0;
    endfunction

    // Advance a diagonal counter, stop at the length limit.
    function int count_step(int v);
        return (v < int'(dmss_pkg::MaxDiagLen)) ? v + 1 : int'(dmss_pkg::MaxDiagLen);
    endfunction

    function void note_input(logic op, logic [dmss_pkg::LetterWidth-1:0] q,
                             logic [dmss_pkg::LetterWidth-1:0] t,
                             logic signed [dmss_pkg::EntryWidth-1:0] v, logic last);
        int                addr;
        dmss_pkg::t_result seg;
        addr = {q, t};
        if (op == dmss_pkg::OpLoad) begin
            subst[addr] = v;
            return;
        end
        run_sum = run_sum + longint'(subst[addr]);
        if (run_sum > longint'(dmss_pkg::SumTop)) begin
            run_sum = longint'(dmss_pkg::SumTop);
        end
        if (run_sum > best_sum) begin
            best_sum   = run_sum;
            best_start = suffix_start;
            cur_len    = count_step(cur_len);
            best_len   = cur_len;
        end else if (run_sum > 0) begin
            cur_len = count_step(cur_len);
        end else begin
            // Drop the suffix: the next segment starts after this pair.
            run_sum      = 0;
            suffix_start = count_step(pos);
            cur_len      = 0;
        end
        pos = count_step(pos);
        if (last) begin
            seg.best_score     = best_sum[dmss_pkg::SumWidth-1:0];
            seg.segment_start  = best_start[dmss_pkg::StartWidth-1:0];
            seg.segment_length = best_len[dmss_pkg::PosWidth-1:0];
            pending_segments.push_back(seg);
            clear_scan();
        end
    endfunction

    function void check_result(logic [dmss_pkg::SumWidth-1:0] score,
                               logic [dmss_pkg::StartWidth-1:0] start,
                               logic [dmss_pkg::PosWidth-1:0] len);
        dmss_pkg::t_result want;
        if (pending_segments.size() == 0) begin
            $display("%0t: unexpected result score=%0d start=%0d length=%0d",
                     $time, score, start, len);
            mismatches++;
            return;
        end
        want = pending_segments.pop_front();
        if (score !== want.best_score) begin
            $display("%0t: best_score expected %0d actual %0d", $time, want.best_score, score);
            mismatches++;
        end
        if (start !== want.segment_start) begin
            $display("%0t: segment_start expected %0d actual %0d",
                     $time, want.segment_start, start);
            mismatches++;
        end
        if (len !== want.segment_length) begin
            $display("%0t: segment_length expected %0d actual %0d",
                     $time, want.segment_length, len);
            mismatches++;
        end
    endfunction
endclass

module tb_diagonal_max_segment_score;

    localparam int WatchdogLimit = 4000;
    localparam int AddrTop       = 0;
    localparam int AddrBottom    = (dmss_pkg::AlphabetSize - 1) * dmss_pkg::AlphabetSize
                                 + dmss_pkg::AlphabetSize - 1;
    localparam int AddrPlus      = 5 * dmss_pkg::AlphabetSize + 10;
    localparam int AddrMinus     = 10 * dmss_pkg::AlphabetSize + 5;
    localparam int AddrZero      = 1 * dmss_pkg::AlphabetSize + 2;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic                                   opcode;
    logic [dmss_pkg::LetterWidth-1:0]       query_letter;
    logic [dmss_pkg::LetterWidth-1:0]       target_letter;
    logic signed [dmss_pkg::EntryWidth-1:0] entry_value;
    logic                                   last_pair;
    logic                                   out_valid;
    logic                                   out_ready;
    logic [dmss_pkg::SumWidth-1:0]          best_score;
    logic [dmss_pkg::StartWidth-1:0]        segment_start;
    logic [dmss_pkg::PosWidth-1:0]          segment_length;

    segment_scoreboard sb;
    int                send_idle_pct;
    int                stall_pct;
    int                items_sent;
    int                stalled_cycles;
    bit                written [dmss_pkg::TableDepth];
    int                written_addrs[$];

    diagonal_max_segment_score u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_query_letter   (query_letter),
        .i_target_letter  (target_letter),
        .i_entry_value    (entry_value),
        .i_last_pair      (last_pair),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_best_score     (best_score),
        .o_segment_start  (segment_start),
        .o_segment_length (segment_length)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(logic op, logic [dmss_pkg::LetterWidth-1:0] q,
                             logic [dmss_pkg::LetterWidth-1:0] t,
                             logic signed [dmss_pkg::EntryWidth-1:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        query_letter  <= q;
        target_letter <= t;
        entry_value   <= v;
        last_pair     <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, q, t, v, last);
        items_sent++;
    endtask

    task automatic load_entry(logic [dmss_pkg::LetterWidth-1:0] q,
                              logic [dmss_pkg::LetterWidth-1:0] t,
                              logic signed [dmss_pkg::EntryWidth-1:0] v, logic last);
        int addr;
        addr = {q, t};
        send_item(dmss_pkg::OpLoad, q, t, v, last);
        if (!written[addr]) begin
            written[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
    endtask

    task automatic send_pair(int addr, logic last);
        send_item(dmss_pkg::OpPair,
                  dmss_pkg::LetterWidth'(addr / dmss_pkg::AlphabetSize),
                  dmss_pkg::LetterWidth'(addr % dmss_pkg::AlphabetSize),
                  dmss_pkg::EntryWidth'($urandom), last);
    endtask

    task automatic random_load();
        logic signed [dmss_pkg::EntryWidth-1:0] v;
        if ($urandom_range(3) == 0) begin
            v = dmss_pkg::EntryWidth'($urandom);
        end else begin
            v = dmss_pkg::EntryWidth'($urandom_range(30)) - dmss_pkg::EntryWidth'(14);
        end
        load_entry(dmss_pkg::LetterWidth'($urandom), dmss_pkg::LetterWidth'($urandom), v,
                   1'($urandom));
    endtask

    // Mostly whole diagonals over loaded entries, with stray loads mixed in.
    task automatic run_phase(int idle_pct, int stall, int count);
        int target;
        int len;
        int i;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(9) == 0) begin
                random_load();
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 16);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(11) == 0) random_load();
                    send_pair(written_addrs[$urandom_range(written_addrs.size() - 1)],
                              i == len - 1);
                end
            end
        end
    endtask

    // Receiver: check accepted results, stall at random.
    initial begin
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                sb.check_result(best_score, segment_start, segment_length);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        stalled_cycles = 0;
        while (stalled_cycles < WatchdogLimit) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        items_sent    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= dmss_pkg::OpLoad;
        query_letter  <= '0;
        target_letter <= '0;
        entry_value   <= '0;
        last_pair     <= 1'b0;
        out_ready     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        load_entry(5'd0, 5'd0, 16'sd32767, 1'b0);
        load_entry(5'd31, 5'd31, -16'sd32768, 1'b0);
        load_entry(5'd5, 5'd10, 16'sd7, 1'b0);
        load_entry(5'd10, 5'd5, -16'sd3, 1'b0);
        load_entry(5'd1, 5'd2, 16'sd0, 1'b0);
        // Last flag on a load: no result.
        load_entry(5'd2, 5'd1, -16'sd1, 1'b1);
        // Nothing positive: all-zero result.
        send_pair(AddrBottom, 1'b1);
        send_pair(AddrZero, 1'b1);
        send_pair(AddrPlus, 1'b0);
        send_pair(AddrPlus, 1'b0);
        send_pair(AddrMinus, 1'b0);
        send_pair(AddrPlus, 1'b1);
        // Restart after the sum drops to zero or below.
        send_pair(AddrMinus, 1'b0);
        send_pair(AddrPlus, 1'b0);
        send_pair(AddrZero, 1'b0);
        send_pair(AddrMinus, 1'b0);
        send_pair(AddrMinus, 1'b0);
        send_pair(AddrMinus, 1'b0);
        send_pair(AddrPlus, 1'b1);
        // Overwrite an entry and read it in the very next transaction.
        load_entry(5'd5, 5'd10, -16'sd5, 1'b0);
        send_pair(AddrPlus, 1'b1);
        send_pair(AddrTop, 1'b1);
        send_pair(AddrTop, 1'b0);
        send_pair(AddrBottom, 1'b0);
        send_pair(AddrTop, 1'b1);

        run_phase(0, 0, 463);
        run_phase(61, 0, 463);
        run_phase(0, 61, 462);
        run_phase(30, 30, 462);
        in_valid <= 1'b0;

        while (sb.pending_segments.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: diagonal_max_segment_score.f
sv/dmss_pkg.sv
sv/dmss_scan.sv
sv/diagonal_max_segment_score.sv
verif/tb_diagonal_max_segment_score.sv
